### hdl/rgb_harmonic_mean_fusion_assert.svh
// assertion macros for the harmonic mean fusion block
`ifndef RGB_HARMONIC_MEAN_FUSION_ASSERT_SVH
`define RGB_HARMONIC_MEAN_FUSION_ASSERT_SVH
`ifndef SYNTH
// check that is ignored while reset is asserted
`define RHMF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// check that also covers the reset cycles
`define RHMF_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RHMF_ASSERT(lbl, prop, msg)
`define RHMF_ASSERT_RST(lbl, prop, msg)
`endif
`endif

### hdl/rhmf_pkg.sv
// shared types and widths for the harmonic mean fusion block
package rhmf_pkg;

  localparam int PIX_W       = 8;
  localparam int PROD_W      = 2 * PIX_W;
  localparam int SUM_W       = PIX_W + 1;
  localparam int P4_W        = 2 * PROD_W;
  localparam int MUL_W       = PROD_W + SUM_W;
  localparam int NUM_W       = P4_W + 2;
  localparam int DEN_W       = MUL_W + 1;
  localparam int DIV_STEPS   = PIX_W;
  localparam int PROD_STAGES = 3;
  localparam int LANE_STAGES = PROD_STAGES + DIV_STEPS;

  typedef struct packed {
    logic [PIX_W-1:0] red_one;
    logic [PIX_W-1:0] red_two;
    logic [PIX_W-1:0] red_three;
    logic [PIX_W-1:0] red_four;
    logic [PIX_W-1:0] green_one;
    logic [PIX_W-1:0] green_two;
    logic [PIX_W-1:0] green_three;
    logic [PIX_W-1:0] green_four;
    logic [PIX_W-1:0] blue_one;
    logic [PIX_W-1:0] blue_two;
    logic [PIX_W-1:0] blue_three;
    logic [PIX_W-1:0] blue_four;
  } pix_in_t;

  typedef struct packed {
    logic [PIX_W-1:0] red_out;
    logic [PIX_W-1:0] green_out;
    logic [PIX_W-1:0] blue_out;
  } pix_out_t;

  // state of one restoring division step
  typedef struct packed {
    logic [NUM_W-1:0] rem;
    logic [NUM_W-1:0] dsh;
    logic [PIX_W-1:0] quo;
    logic             zero;
  } div_data_t;

endpackage

### hdl/rhmf_div_step.sv
// one registered restoring division step, one quotient bit
module rhmf_div_step (
  input  logic                  clk,
  input  logic                  en,
  input  rhmf_pkg::div_data_t   d_i,
  output rhmf_pkg::div_data_t   d_o
);

  rhmf_pkg::div_data_t step_r;
  rhmf_pkg::div_data_t step_nxt;
  logic                ge;

  always_comb begin
    ge             = (d_i.rem >= d_i.dsh);
    step_nxt.rem   = ge ? (d_i.rem - d_i.dsh) : d_i.rem;
    step_nxt.dsh   = d_i.dsh >> 1;
    step_nxt.quo   = {d_i.quo[rhmf_pkg::PIX_W-2:0], ge};
    step_nxt.zero  = d_i.zero;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      step_r <= step_nxt;
    end
  end

  assign d_o = step_r;

endmodule

### hdl/rhmf_lane.sv
// one color channel: product stages then a chain of division steps
module rhmf_lane (
  input  logic                                clk,
  input  logic [rhmf_pkg::LANE_STAGES-1:0]    en,
  input  logic [rhmf_pkg::PIX_W-1:0]          a,
  input  logic [rhmf_pkg::PIX_W-1:0]          b,
  input  logic [rhmf_pkg::PIX_W-1:0]          c,
  input  logic [rhmf_pkg::PIX_W-1:0]          d,
  output logic [rhmf_pkg::PIX_W-1:0]          mean
);

  localparam int PS = rhmf_pkg::PROD_STAGES;
  localparam int DS = rhmf_pkg::DIV_STEPS;

  // stage 0: pair products and pair sums
  logic [rhmf_pkg::PROD_W-1:0] ab_r, cd_r;
  logic [rhmf_pkg::SUM_W-1:0]  sab_r, scd_r;
  logic                        z0_r;
  // stage 1: full product and the two halves of the denominator
  logic [rhmf_pkg::P4_W-1:0]   p_r;
  logic [rhmf_pkg::MUL_W-1:0]  m1_r, m2_r;
  logic                        z1_r;
  // stage 2: divider setup
  rhmf_pkg::div_data_t         init_r;
  logic [rhmf_pkg::DEN_W-1:0]  den;

  rhmf_pkg::div_data_t         chain [DS+1];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      ab_r  <= rhmf_pkg::PROD_W'(a) * rhmf_pkg::PROD_W'(b);
      cd_r  <= rhmf_pkg::PROD_W'(c) * rhmf_pkg::PROD_W'(d);
      sab_r <= rhmf_pkg::SUM_W'(a) + rhmf_pkg::SUM_W'(b);
      scd_r <= rhmf_pkg::SUM_W'(c) + rhmf_pkg::SUM_W'(d);
      z0_r  <= (a == '0) || (b == '0) || (c == '0) || (d == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      p_r  <= rhmf_pkg::P4_W'(ab_r) * rhmf_pkg::P4_W'(cd_r);
      m1_r <= rhmf_pkg::MUL_W'(cd_r) * rhmf_pkg::MUL_W'(sab_r);
      m2_r <= rhmf_pkg::MUL_W'(ab_r) * rhmf_pkg::MUL_W'(scd_r);
      z1_r <= z0_r;
    end
  end

  // bcd+acd+abd+abc = cd*(a+b) + ab*(c+d)
  assign den = rhmf_pkg::DEN_W'(m1_r) + rhmf_pkg::DEN_W'(m2_r);

  always_ff @(posedge clk) begin
    if (en[2]) begin
      init_r.rem  <= {p_r, 2'b00};
      init_r.dsh  <= rhmf_pkg::NUM_W'(den) << (DS - 1);
      init_r.quo  <= '0;
      init_r.zero <= z1_r;
    end
  end

  assign chain[0] = init_r;

  for (genvar k = 0; k < DS; k++) begin : g_step
    rhmf_div_step u_step (
      .clk (clk),
      .en  (en[PS + k]),
      .d_i (chain[k]),
      .d_o (chain[k+1])
    );
  end

  // any zero sample forces the channel to zero
  assign mean = chain[DS].zero ? '0 : chain[DS].quo;

endmodule

### hdl/rgb_harmonic_mean_fusion.sv
// harmonic mean fusion of four rgb pixels, top level
// 12 register stages in all: the lane stages, then the output register
// throughput: one word per cycle while out_stall is low; three channel lanes run in lockstep
// each lane: 2 multiply stages, a divider setup stage, then 8 restoring divide steps
// stages advance independently, so bubbles collapse while the output is stalled
// reset (rst_n, synchronous) clears all valid bits; data registers are not reset
module rgb_harmonic_mean_fusion (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  rhmf_pkg::pix_in_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output rhmf_pkg::pix_out_t out_data
);

`include "rgb_harmonic_mean_fusion_assert.svh"

  localparam int NS = rhmf_pkg::LANE_STAGES;

  // valid bit for each lane stage, shared by all three lanes
  logic [NS-1:0]         vld_r;
  logic [NS-1:0]         vld_nxt;
  // rdy[k]: stage k may load this cycle; rdy[NS] is the output register
  logic [NS:0]           rdy;

  logic [rhmf_pkg::PIX_W-1:0] red_mean, green_mean, blue_mean;

  rhmf_pkg::pix_out_t    out_r;
  logic                  out_valid_r;
  logic                  out_valid_nxt;

  // ready ripples back: a stage loads when empty or when its successor loads
  always_comb begin
    rdy[NS] = !out_valid_r || !out_stall;
    for (int k = NS - 1; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
  end

  assign in_stall = !rdy[0];

  always_comb begin
    vld_nxt = vld_r;
    if (rdy[0]) begin
      vld_nxt[0] = in_valid;
    end
    for (int k = 1; k < NS; k++) begin
      if (rdy[k]) begin
        vld_nxt[k] = vld_r[k-1];
      end
    end
    out_valid_nxt = out_valid_r;
    if (rdy[NS]) begin
      out_valid_nxt = vld_r[NS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      vld_r       <= vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // one lane per color channel
  rhmf_lane u_red (
    .clk  (clk),
    .en   (rdy[NS-1:0]),
    .a    (in_data.red_one),
    .b    (in_data.red_two),
    .c    (in_data.red_three),
    .d    (in_data.red_four),
    .mean (red_mean)
  );

  rhmf_lane u_green (
    .clk  (clk),
    .en   (rdy[NS-1:0]),
    .a    (in_data.green_one),
    .b    (in_data.green_two),
    .c    (in_data.green_three),
    .d    (in_data.green_four),
    .mean (green_mean)
  );

  rhmf_lane u_blue (
    .clk  (clk),
    .en   (rdy[NS-1:0]),
    .a    (in_data.blue_one),
    .b    (in_data.blue_two),
    .c    (in_data.blue_three),
    .d    (in_data.blue_four),
    .mean (blue_mean)
  );

  // merge the three lane results into the output word
  always_ff @(posedge clk) begin
    if (rdy[NS]) begin
      out_r.red_out   <= red_mean;
      out_r.green_out <= green_mean;
      out_r.blue_out  <= blue_mean;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // an accepted word enters the first stage
  `RHMF_ASSERT(a_accept_enters, (in_valid && !in_stall) |=> vld_r[0], "accepted word lost at entry")
  // a word in the last lane stage that cannot move must still be there next cycle
  `RHMF_ASSERT(a_tail_holds, (vld_r[NS-1] && !rdy[NS]) |=> vld_r[NS-1], "word dropped at pipeline tail")
  // reset empties the output register
  `RHMF_ASSERT_RST(a_reset_empty, !rst_n |=> !out_valid, "output valid after reset")

endmodule

### tb/rgb_harmonic_mean_fusion_test.sv
// self-checking testbench for the rgb harmonic mean fusion block
module rgb_harmonic_mean_fusion_test;

  // cycles with no word moving on either side before the run is declared hung
  localparam int HANG_LIMIT   = 5000;
  // long output hold-off, well past the pipeline depth so the input must stall
  localparam int HOLD_CYCLES  = 200;
  // cycles to let the pipeline settle after the last expected word
  localparam int SETTLE       = 20;
  localparam int PHASE_WORDS  = 500;

  // idle/stall percentages of the traffic phases
  localparam int PCT_NONE     = 0;
  localparam int PCT_HEAVY    = 82;
  localparam int PCT_MIXED    = 30;

  // scoreboard: predicts the fused pixel for each accepted input word and
  // matches it against output words in order
  class fused_pixel_board;
    rhmf_pkg::pix_out_t pending_pixels[$];
    int                 errors;
    int                 words_out;

    task report(string msg);
      $display("%0t: %s", $time, msg);
      errors++;
    endtask

    // floor(4abcd / (bcd+acd+abd+abc)), zero when any value is zero
    function automatic logic [rhmf_pkg::PIX_W-1:0] harmonic_mean4(
        logic [rhmf_pkg::PIX_W-1:0] a, logic [rhmf_pkg::PIX_W-1:0] b,
        logic [rhmf_pkg::PIX_W-1:0] c, logic [rhmf_pkg::PIX_W-1:0] d);
      longint unsigned wa = a;
      longint unsigned wb = b;
      longint unsigned wc = c;
      longint unsigned wd = d;
      longint unsigned num;
      longint unsigned den;
      longint unsigned quo;
      if (a == 0 || b == 0 || c == 0 || d == 0) return '0;
      num = 4 * wa * wb * wc * wd;
      den = wb * wc * wd + wa * wc * wd + wa * wb * wd + wa * wb * wc;
      quo = num / den;
      return quo[rhmf_pkg::PIX_W-1:0];
    endfunction

    function void note_pixel_in(rhmf_pkg::pix_in_t w);
      rhmf_pkg::pix_out_t fused;
      fused.red_out   = harmonic_mean4(w.red_one, w.red_two, w.red_three, w.red_four);
      fused.green_out = harmonic_mean4(w.green_one, w.green_two, w.green_three,
                                       w.green_four);
      fused.blue_out  = harmonic_mean4(w.blue_one, w.blue_two, w.blue_three, w.blue_four);
      pending_pixels.insert(pending_pixels.size(), fused);
    endfunction

    task check_pixel_out(rhmf_pkg::pix_out_t got);
      rhmf_pkg::pix_out_t want;
      if (pending_pixels.size() == 0) begin
        report($sformatf("output word %0d with nothing expected", words_out));
      end else begin
        want = pending_pixels.pop_front();
        if (got.red_out !== want.red_out)
          report($sformatf("word %0d red: got %0d expected %0d",
                           words_out, got.red_out, want.red_out));
        if (got.green_out !== want.green_out)
          report($sformatf("word %0d green: got %0d expected %0d",
                           words_out, got.green_out, want.green_out));
        if (got.blue_out !== want.blue_out)
          report($sformatf("word %0d blue: got %0d expected %0d",
                           words_out, got.blue_out, want.blue_out));
      end
      words_out++;
    endtask

    task check_leftovers();
      if (pending_pixels.size() != 0)
        report($sformatf("%0d expected words never came out", pending_pixels.size()));
    endtask
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  rhmf_pkg::pix_in_t  in_data;
  logic               out_valid;
  logic               out_stall;
  rhmf_pkg::pix_out_t out_data;

  // traffic shaping, set at rising edges, read at falling edges, where the receiver also clears hold_request
  int send_idle_pct;
  int stall_pct;
  int hold_request;

  fused_pixel_board board;

  rgb_harmonic_mean_fusion i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // monitor: both channels sampled at the rising edge, before the block updates
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) board.note_pixel_in(in_data);
      if (out_valid && !out_stall) board.check_pixel_out(out_data);
    end
  end

  // receiver: random stall per cycle, or a long hold-off counted down here
  initial begin
    int hold_left;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        out_stall = 1'b1;
        hold_left--;
      end else begin
        out_stall = ($urandom_range(99) < stall_pct);
      end
    end
  end

  // watchdog: ends the run if no word moves for too long
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < HANG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  // channel value biased toward zero, the low end and the top end
  function automatic logic [rhmf_pkg::PIX_W-1:0] pick_value();
    int r;
    r = $urandom_range(99);
    if (r < 6) return '0;
    if (r < 16) return rhmf_pkg::PIX_W'($urandom_range(1, 3));
    if (r < 26) return rhmf_pkg::PIX_W'($urandom_range(250, 255));
    return rhmf_pkg::PIX_W'($urandom_range(0, 255));
  endfunction

  // four values of one channel: sometimes all equal, where exact division matters
  function automatic logic [4*rhmf_pkg::PIX_W-1:0] pick_channel();
    logic [rhmf_pkg::PIX_W-1:0] v;
    if ($urandom_range(99) < 20) begin
      v = pick_value();
      return {v, v, v, v};
    end
    return {pick_value(), pick_value(), pick_value(), pick_value()};
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance;
  // valid stays high into the next word unless the sender idles
  task automatic send_word(rhmf_pkg::pix_in_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = w;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic send_pixel(logic [4*rhmf_pkg::PIX_W-1:0] red,
                            logic [4*rhmf_pkg::PIX_W-1:0] green,
                            logic [4*rhmf_pkg::PIX_W-1:0] blue);
    send_word(rhmf_pkg::pix_in_t'({red, green, blue}));
  endtask

  // called at a falling edge: drop valid, then wait for every expected word
  task automatic drain();
    in_valid = 1'b0;
    while (board.pending_pixels.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_traffic(int idle_pct, int stall);
    @(posedge clk);
    send_idle_pct = idle_pct;
    stall_pct     = stall;
    @(negedge clk);
  endtask

  task automatic send_random(int count);
    repeat (count) send_pixel(pick_channel(), pick_channel(), pick_channel());
  endtask

  initial begin
    board         = new;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    send_idle_pct = PCT_NONE;
    stall_pct     = PCT_NONE;
    hold_request  = 0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed words: extremes, equal values, a zero in every position
    send_pixel({4{8'd0}}, {4{8'd0}}, {4{8'd0}});
    send_pixel({4{8'd255}}, {4{8'd255}}, {4{8'd255}});
    send_pixel({4{8'd1}}, {4{8'd2}}, {4{8'd3}});
    send_pixel({4{8'd7}}, {4{8'd100}}, {4{8'd200}});
    send_pixel({4{8'd128}}, {4{8'd254}}, {4{8'd127}});
    send_pixel({8'd0, 8'd255, 8'd255, 8'd255}, {8'd255, 8'd0, 8'd255, 8'd255},
               {8'd255, 8'd255, 8'd0, 8'd255});
    send_pixel({8'd255, 8'd255, 8'd255, 8'd0}, {8'd0, 8'd1, 8'd1, 8'd1},
               {8'd1, 8'd0, 8'd0, 8'd0});
    send_pixel({8'd1, 8'd255, 8'd255, 8'd255}, {8'd255, 8'd1, 8'd1, 8'd1},
               {8'd1, 8'd1, 8'd255, 8'd255});
    send_pixel({8'd1, 8'd2, 8'd3, 8'd4}, {8'd128, 8'd64, 8'd32, 8'd16},
               {8'd255, 8'd254, 8'd253, 8'd252});
    send_pixel({8'h55, 8'haa, 8'h55, 8'haa}, {8'haa, 8'h55, 8'haa, 8'h55},
               {8'h0f, 8'hf0, 8'h0f, 8'hf0});
    send_pixel({8'd255, 8'd255, 8'd255, 8'd254}, {8'd2, 8'd2, 8'd2, 8'd3},
               {8'd200, 8'd100, 8'd50, 8'd25});
    send_pixel({8'd1, 8'd1, 8'd1, 8'd2}, {8'd3, 8'd6, 8'd9, 8'd18},
               {8'd254, 8'd255, 8'd1, 8'd128});
    drain();

    // full rate, with a long output hold-off so the pipeline backs up
    set_traffic(PCT_NONE, PCT_NONE);
    @(posedge clk);
    hold_request = HOLD_CYCLES;
    @(negedge clk);
    send_random(PHASE_WORDS);
    drain();

    // sparse input
    set_traffic(PCT_HEAVY, PCT_NONE);
    send_random(PHASE_WORDS);
    drain();

    // heavy output stalls
    set_traffic(PCT_NONE, PCT_HEAVY);
    send_random(PHASE_WORDS);
    drain();

    // both sides idle now and then
    set_traffic(PCT_MIXED, PCT_MIXED);
    send_random(PHASE_WORDS);
    drain();

    repeat (SETTLE) @(posedge clk);
    board.check_leftovers();
    if (board.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
